FILE: hw/rtl/nhct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhct_pkg: next-hop cost table shared definitions
// Field widths, operation and status codes, and the stored entry layout.
// ----------------------------------------------------------------------------
package nhct_pkg;

  // Default number of table entries
  localparam int unsigned TABLE_DEPTH = 16;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned FACE_W   = 32;
  localparam int unsigned COST_W   = 16;
  localparam int unsigned STATUS_W = 3;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SORT   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOWERED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_KEPT      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_LIST      = 3'd6;

  // One stored next hop
  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [COST_W-1:0] cost;
  } entry_t;

  localparam int unsigned ENTRY_W = FACE_W + COST_W;

  // One result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FACE_W-1:0]   face;
    logic [COST_W-1:0]   cost;
    logic                present;
    logic                last;
  } result_t;

endpackage

FILE: hw/rtl/nhct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nhct_ram: generic single-write, single-read RAM
// One write port and one read port per cycle; read data is registered.
// ----------------------------------------------------------------------------
module nhct_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port (old data on a same-address write)
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/next_hop_cost_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_hop_cost_table: ordered next-hop list with cost update, remove, sort
// A command is taken when start is high and busy is low; results come out
// on done_o, one word per cycle, and cannot be held off by the receiver.
// With n stored entries, add and remove scan one entry per cycle through the
// single read port of the entry RAM; a remove stops its scan at the match,
// and the entries behind it close the gap one entry a cycle.
// Sort is an insertion sort on that same port: it picks up each entry as the
// key, moves the earlier entries that cost more than the key up one slot,
// and puts the key in the freed slot. The list follows: n words, one per
// cycle (one word for an empty table), the final one marked by last_o.
// Mode 3 is ignored and yields no word. No clearing pass runs after reset;
// only data from occupied entries is ever used.
// ----------------------------------------------------------------------------
module next_hop_cost_table #(
  parameter int unsigned TABLE_DEPTH = nhct_pkg::TABLE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [nhct_pkg::MODE_W-1:0]   mode_i,
  input  logic [nhct_pkg::FACE_W-1:0]   face_i,
  input  logic [nhct_pkg::COST_W-1:0]   cost_i,
  output logic                          done_o,
  output logic [nhct_pkg::STATUS_W-1:0] status_o,
  output logic [nhct_pkg::FACE_W-1:0]   entry_face_o,
  output logic [nhct_pkg::COST_W-1:0]   entry_cost_o,
  output logic                          entry_present_o,
  output logic                          last_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CMP      = 4'd1;
  localparam logic [3:0] S_MISS     = 4'd2;
  localparam logic [3:0] S_SHIFT    = 4'd3;
  localparam logic [3:0] S_SORT_KEY = 4'd4;
  localparam logic [3:0] S_SORT_CMP = 4'd5;
  localparam logic [3:0] S_SORT_PUT = 4'd6;
  localparam logic [3:0] S_LIST     = 4'd7;
  localparam logic [3:0] S_LIST_OUT = 4'd8;

  logic [3:0]                  state_q, state_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic [AW-1:0]               j_q, j_d;
  logic [CW-1:0]               count_q, count_d;
  logic [nhct_pkg::MODE_W-1:0] mode_q, mode_d;
  nhct_pkg::entry_t            key_q, key_d;
  nhct_pkg::result_t           res_q, res_d;
  logic                        done_q, done_d;

  // RAM port signals
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  nhct_pkg::entry_t             ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [nhct_pkg::ENTRY_W-1:0] ram_rdata;
  nhct_pkg::entry_t             rd;

  // Index helpers
  logic [CW-1:0] idx_ext;
  logic          idx_p1_end;
  logic          idx_p2_end;

  assign rd         = nhct_pkg::entry_t'(ram_rdata);
  assign idx_ext    = CW'(idx_q);
  assign idx_p1_end = (idx_ext + CW'(1)) == count_q;
  assign idx_p2_end = (idx_ext + CW'(2)) == count_q;

  nhct_ram #(
    .DATA_W (nhct_pkg::ENTRY_W),
    .DEPTH  (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    j_d       = j_q;
    count_d   = count_q;
    mode_d    = mode_q;
    key_d     = key_q;
    res_d     = res_q;
    done_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = key_q;
    ram_raddr = idx_q + AW'(1);

    case (state_q)
      S_IDLE: begin
        ram_raddr = '0;
        if (start) begin
          mode_d     = mode_i;
          key_d.face = face_i;
          key_d.cost = cost_i;
          idx_d      = '0;
          case (mode_i)
            nhct_pkg::MODE_ADD, nhct_pkg::MODE_REMOVE: begin
              state_d = (count_q == '0) ? S_MISS : S_CMP;
            end
            nhct_pkg::MODE_SORT: begin
              if (count_q < CW'(2)) begin
                state_d = S_LIST;
              end else begin
                ram_raddr = AW'(1);
                idx_d     = AW'(1);
                state_d   = S_SORT_KEY;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Compare entry idx against the key; next entry read is in flight
      S_CMP: begin
        if (mode_q == nhct_pkg::MODE_ADD && rd.face == key_q.face) begin
          res_d   = '{status: nhct_pkg::ST_KEPT, face: '0, cost: rd.cost,
                      present: 1'b0, last: 1'b1};
          if (key_q.cost < rd.cost) begin
            ram_we     = 1'b1;
            res_d.status = nhct_pkg::ST_LOWERED;
            res_d.cost   = key_q.cost;
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (mode_q == nhct_pkg::MODE_REMOVE && rd.face == key_q.face &&
                     rd.cost == key_q.cost) begin
          if (idx_p1_end) begin
            count_d = count_q - CW'(1);
            res_d   = '{status: nhct_pkg::ST_REMOVED, face: '0, cost: '0,
                        present: 1'b0, last: 1'b1};
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_SHIFT;
          end
        end else if (idx_p1_end) begin
          state_d = S_MISS;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end

      // No matching entry: append, full, or not found
      S_MISS: begin
        done_d = 1'b1;
        res_d  = '{status: nhct_pkg::ST_NOT_FOUND, face: '0, cost: '0,
                   present: 1'b0, last: 1'b1};
        if (mode_q == nhct_pkg::MODE_ADD) begin
          if (count_q == CW'(TABLE_DEPTH)) begin
            res_d.status = nhct_pkg::ST_FULL;
          end else begin
            ram_we       = 1'b1;
            ram_waddr    = count_q[AW-1:0];
            count_d      = count_q + CW'(1);
            res_d.status = nhct_pkg::ST_APPENDED;
            res_d.cost   = key_q.cost;
          end
        end
        state_d = S_IDLE;
      end

      // Close the gap: entry idx+1 is on the read port, goes to idx
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_wdata = rd;
        ram_raddr = idx_q + AW'(2);
        if (idx_p2_end) begin
          count_d = count_q - CW'(1);
          res_d   = '{status: nhct_pkg::ST_REMOVED, face: '0, cost: '0,
                      present: 1'b0, last: 1'b1};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end

      // Insertion sort: pick up entry idx as the key
      S_SORT_KEY: begin
        key_d     = rd;
        j_d       = idx_q;
        ram_raddr = idx_q - AW'(1);
        state_d   = S_SORT_CMP;
      end

      // Entry j-1 on the read port: move it up if it costs more than the key
      S_SORT_CMP: begin
        ram_raddr = j_q - AW'(1) - AW'(1);
        if (rd.cost > key_q.cost) begin
          ram_we    = 1'b1;
          ram_waddr = j_q;
          ram_wdata = rd;
          j_d       = j_q - AW'(1);
          if (j_q == AW'(1)) begin
            state_d = S_SORT_PUT;
          end
        end else begin
          state_d = S_SORT_PUT;
        end
      end

      // Drop the key into its slot and fetch the next one
      S_SORT_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = key_q;
        if (idx_p1_end) begin
          state_d = S_LIST;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_SORT_KEY;
        end
      end

      // Start the listing
      S_LIST: begin
        ram_raddr = '0;
        idx_d     = '0;
        if (count_q == '0) begin
          res_d   = '{status: nhct_pkg::ST_LIST, face: '0, cost: '0,
                      present: 1'b0, last: 1'b1};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_LIST_OUT;
        end
      end

      // One list word per cycle
      S_LIST_OUT: begin
        res_d  = '{status: nhct_pkg::ST_LIST, face: rd.face, cost: rd.cost,
                   present: 1'b1, last: idx_p1_end};
        done_d = 1'b1;
        if (idx_p1_end) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    j_q    <= j_d;
    mode_q <= mode_d;
    key_q  <= key_d;
    res_q  <= res_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = res_q.status;
  assign entry_face_o    = res_q.face;
  assign entry_cost_o    = res_q.cost;
  assign entry_present_o = res_q.present;
  assign last_o          = res_q.last;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + 1) ||
    (count_q + 1 == $past(count_q)))
    else $error("entry count moved by more than one");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && last_o) |-> !busy)
    else $error("final word while still busy");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !last_o) |-> busy)
    else $error("list word without a following word");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the next-hop cost table
// Drives add, remove, sort and unused commands through the start/busy
// handshake. A directed table covers the empty, extreme, full and tie
// cases, then random traffic runs over a small face pool so that lookups hit.
// A table-shadow model predicts every result word, and each word seen on
// done_o is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam time         CLK_HALF    = 5ns;
  localparam time         TIMEOUT     = 5ms;
  localparam int          DRAIN_CYC   = 400;
  localparam int          RAND_ITEMS  = 225;
  localparam int          POOL_SIZE   = 24;
  localparam logic [nhct_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  // One directed row; want is used only when typed is set
  typedef struct {
    logic [nhct_pkg::MODE_W-1:0] mode;
    logic [nhct_pkg::FACE_W-1:0] face;
    logic [nhct_pkg::COST_W-1:0] cost;
    bit                          typed;
    nhct_pkg::result_t           want;
  } dir_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [nhct_pkg::MODE_W-1:0]   mode_i = '0;
  logic [nhct_pkg::FACE_W-1:0]   face_i = '0;
  logic [nhct_pkg::COST_W-1:0]   cost_i = '0;
  logic                          done_o;
  logic [nhct_pkg::STATUS_W-1:0] status_o;
  logic [nhct_pkg::FACE_W-1:0]   entry_face_o;
  logic [nhct_pkg::COST_W-1:0]   entry_cost_o;
  logic                          entry_present_o;
  logic                          last_o;

  // Shadow copy of the hop table
  logic [nhct_pkg::FACE_W-1:0] hop_face [nhct_pkg::TABLE_DEPTH];
  logic [nhct_pkg::COST_W-1:0] hop_cost [nhct_pkg::TABLE_DEPTH];
  int                          hop_count = 0;

  nhct_pkg::result_t           hop_expect[$];
  dir_row_t                    dir_rows[$];
  logic [nhct_pkg::FACE_W-1:0] face_pool [POOL_SIZE];

  // Typed expectation that rides along with the current word
  bit                row_typed = 1'b0;
  nhct_pkg::result_t row_word  = '0;
  int                idle_pct  = 0;
  int                err_count = 0;

  next_hop_cost_table u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .face_i         (face_i),
    .cost_i         (cost_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .entry_face_o   (entry_face_o),
    .entry_cost_o   (entry_cost_o),
    .entry_present_o(entry_present_o),
    .last_o         (last_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Append one predicted word at the back of the queue
  task automatic queue_word(input nhct_pkg::result_t w);
    hop_expect.insert(hop_expect.size(), w);
  endtask

  // Apply one command to the shadow table and queue the words it yields
  task automatic predict_hop_op(input logic [nhct_pkg::MODE_W-1:0] op,
                                input logic [nhct_pkg::FACE_W-1:0] f,
                                input logic [nhct_pkg::COST_W-1:0] c);
    nhct_pkg::result_t           w;
    int                          i;
    int                          j;
    int                          hit;
    logic [nhct_pkg::FACE_W-1:0] kf;
    logic [nhct_pkg::COST_W-1:0] kc;
    w = '0;
    w.last = 1'b1;
    hit = -1;
    case (op)
      nhct_pkg::MODE_ADD: begin
        for (i = 0; i < hop_count; i++)
          if (hit < 0 && hop_face[i] == f) hit = i;
        if (hit >= 0) begin
          if (hop_cost[hit] > c) begin
            hop_cost[hit] = c;
            w.status = nhct_pkg::ST_LOWERED;
            w.cost = c;
          end else begin
            w.status = nhct_pkg::ST_KEPT;
            w.cost = hop_cost[hit];
          end
        end else if (hop_count >= nhct_pkg::TABLE_DEPTH) begin
          w.status = nhct_pkg::ST_FULL;
        end else begin
          hop_face[hop_count] = f;
          hop_cost[hop_count] = c;
          hop_count++;
          w.status = nhct_pkg::ST_APPENDED;
          w.cost = c;
        end
        queue_word(w);
      end
      nhct_pkg::MODE_REMOVE: begin
        for (i = 0; i < hop_count; i++)
          if (hit < 0 && hop_face[i] == f && hop_cost[i] == c) hit = i;
        if (hit >= 0) begin
          // later entries close the gap in order
          for (j = hit; j + 1 < hop_count; j++) begin
            hop_face[j] = hop_face[j + 1];
            hop_cost[j] = hop_cost[j + 1];
          end
          hop_count--;
          w.status = nhct_pkg::ST_REMOVED;
        end else begin
          w.status = nhct_pkg::ST_NOT_FOUND;
        end
        queue_word(w);
      end
      nhct_pkg::MODE_SORT: begin
        // stable insertion sort: equal costs keep their order
        for (i = 1; i < hop_count; i++) begin
          kf = hop_face[i];
          kc = hop_cost[i];
          j = i;
          while (j > 0 && hop_cost[j - 1] > kc) begin
            hop_face[j] = hop_face[j - 1];
            hop_cost[j] = hop_cost[j - 1];
            j--;
          end
          hop_face[j] = kf;
          hop_cost[j] = kc;
        end
        w.status = nhct_pkg::ST_LIST;
        if (hop_count == 0) begin
          queue_word(w);
        end else begin
          for (i = 0; i < hop_count; i++) begin
            w.face = hop_face[i];
            w.cost = hop_cost[i];
            w.present = 1'b1;
            w.last = (i + 1 == hop_count);
            queue_word(w);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Predict at acceptance, then check any word on the result ports
  always @(posedge clk_i) begin : check_blk
    int                n_before;
    nhct_pkg::result_t got;
    nhct_pkg::result_t want;
    if (rst_ni && start && !busy) begin
      n_before = hop_expect.size();
      predict_hop_op(mode_i, face_i, cost_i);
      if (row_typed && hop_expect.size() > n_before)
        hop_expect[hop_expect.size() - 1] = row_word;
    end
    if (rst_ni && done_o) begin
      got.status = status_o;
      got.face = entry_face_o;
      got.cost = entry_cost_o;
      got.present = entry_present_o;
      got.last = last_o;
      if (hop_expect.size() == 0) begin
        $display("%0t: unexpected word, expected none, got status %0d face %h cost %h",
                 $time, got.status, got.face, got.cost);
        err_count++;
      end else begin
        want = hop_expect.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          err_count++;
        end
        if (got.face !== want.face) begin
          $display("%0t: entry_face expected %h got %h", $time, want.face, got.face);
          err_count++;
        end
        if (got.cost !== want.cost) begin
          $display("%0t: entry_cost expected %h got %h", $time, want.cost, got.cost);
          err_count++;
        end
        if (got.present !== want.present) begin
          $display("%0t: entry_present expected %b got %b", $time, want.present,
                   got.present);
          err_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %b got %b", $time, want.last, got.last);
          err_count++;
        end
      end
    end
  end

  // Directed row; st and wc form a typed single-word answer when typed is set
  task automatic add_row(input logic [nhct_pkg::MODE_W-1:0] m,
                         input logic [nhct_pkg::FACE_W-1:0] f,
                         input logic [nhct_pkg::COST_W-1:0] c, input bit typed,
                         input logic [nhct_pkg::STATUS_W-1:0] st,
                         input logic [nhct_pkg::COST_W-1:0] wc);
    dir_row_t r;
    r.mode = m;
    r.face = f;
    r.cost = c;
    r.typed = typed;
    r.want = '0;
    r.want.status = st;
    r.want.cost = wc;
    r.want.last = 1'b1;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // Present one word at a falling edge and hold it until it is taken
  task automatic send_word(input logic [nhct_pkg::MODE_W-1:0] m,
                           input logic [nhct_pkg::FACE_W-1:0] f,
                           input logic [nhct_pkg::COST_W-1:0] c, input bit typed,
                           input nhct_pkg::result_t w);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    mode_i = m;
    face_i = f;
    cost_i = c;
    row_typed = typed;
    row_word = w;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold off until every predicted word has come out
  task automatic drain_words();
    start = 1'b0;
    while (hop_expect.size() != 0) @(negedge clk_i);
  endtask

  initial begin : stim_blk
    int                          k;
    int                          phase;
    int                          pick;
    int                          idx;
    logic [nhct_pkg::MODE_W-1:0] m;
    logic [nhct_pkg::FACE_W-1:0] f;
    logic [nhct_pkg::COST_W-1:0] c;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty table, extremes, tie on update, unused mode, partial match
    add_row(nhct_pkg::MODE_SORT, 32'h0, 16'h0, 1, nhct_pkg::ST_LIST, 16'h0);
    add_row(nhct_pkg::MODE_REMOVE, 32'h0, 16'h0, 1, nhct_pkg::ST_NOT_FOUND, 16'h0);
    add_row(nhct_pkg::MODE_ADD, 32'hFFFF_FFFF, 16'hFFFF, 1, nhct_pkg::ST_APPENDED,
            16'hFFFF);
    add_row(nhct_pkg::MODE_ADD, 32'h0, 16'h0, 1, nhct_pkg::ST_APPENDED, 16'h0);
    add_row(nhct_pkg::MODE_ADD, 32'hFFFF_FFFF, 16'h0, 1, nhct_pkg::ST_LOWERED, 16'h0);
    add_row(nhct_pkg::MODE_ADD, 32'h0, 16'h5, 1, nhct_pkg::ST_KEPT, 16'h0);
    add_row(nhct_pkg::MODE_ADD, 32'hFFFF_FFFF, 16'h0, 1, nhct_pkg::ST_KEPT, 16'h0);
    add_row(MODE_UNUSED, 32'h1, 16'h1, 0, nhct_pkg::ST_APPENDED, 16'h0);
    add_row(nhct_pkg::MODE_REMOVE, 32'h0, 16'h5, 1, nhct_pkg::ST_NOT_FOUND, 16'h0);
    // fill to capacity with repeated costs so the sort sees ties
    for (k = 0; k < nhct_pkg::TABLE_DEPTH - 2; k++)
      add_row(nhct_pkg::MODE_ADD, 32'h100 + k, 16'((k * 3) % 5) * 16'd1000, 0,
              nhct_pkg::ST_APPENDED, 16'h0);
    add_row(nhct_pkg::MODE_ADD, 32'hABCD_0001, 16'h7, 1, nhct_pkg::ST_FULL, 16'h0);
    add_row(nhct_pkg::MODE_SORT, 32'h0, 16'h0, 0, nhct_pkg::ST_APPENDED, 16'h0);
    add_row(nhct_pkg::MODE_REMOVE, 32'h0, 16'h0, 0, nhct_pkg::ST_APPENDED, 16'h0);

    idle_pct = 20;
    foreach (dir_rows[i])
      send_word(dir_rows[i].mode, dir_rows[i].face, dir_rows[i].cost, dir_rows[i].typed,
                dir_rows[i].want);
    drain_words();

    // random traffic over a small face pool so adds and removes hit
    face_pool[0] = 32'h0;
    face_pool[1] = 32'hFFFF_FFFF;
    for (k = 2; k < POOL_SIZE; k++) face_pool[k] = $urandom;
    row_word = '0;
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 20 : (phase == 1) ? 47 : 0;
      for (k = 0; k < RAND_ITEMS / 3; k++) begin
        pick = $urandom_range(99);
        c = ($urandom_range(1) != 0) ? 16'($urandom_range(7)) : 16'($urandom_range(65535));
        f = face_pool[$urandom_range(POOL_SIZE - 1)];
        if (pick < 45) begin
          m = nhct_pkg::MODE_ADD;
        end else if (pick < 50) begin
          m = nhct_pkg::MODE_ADD;
          f = $urandom;
        end else if (pick < 80) begin
          m = nhct_pkg::MODE_REMOVE;
          // mostly remove a stored entry exactly
          if (hop_count > 0 && $urandom_range(99) < 60) begin
            idx = $urandom_range(hop_count - 1);
            f = hop_face[idx];
            c = hop_cost[idx];
          end
        end else if (pick < 95) begin
          m = nhct_pkg::MODE_SORT;
        end else begin
          m = MODE_UNUSED;
        end
        send_word(m, f, c, 1'b0, row_word);
      end
      drain_words();
    end

    start = 1'b0;
    drain_words();
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #(TIMEOUT);
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/nhct_pkg.sv
hw/rtl/nhct_ram.sv
hw/rtl/next_hop_cost_table.sv
tb/testbench.sv
